[hdl/vector_radius_clamp_defines.svh]
// ----------------------------------------------------------------------------
// vector_radius_clamp assertion macros
// Concurrent checks used by the top level; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef VECTOR_RADIUS_CLAMP_DEFINES_SVH
`define VECTOR_RADIUS_CLAMP_DEFINES_SVH

`ifndef SYNTHESIS
// next-cycle implication, off during reset
`define VRC_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vrc assertion failed");
// next-cycle implication, always on
`define VRC_ASSERT_NEXT_ALWAYS(name, clk, pre, post) \
  name: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("vrc assertion failed");
`else
`define VRC_ASSERT_NEXT(name, clk, rst, pre, post)
`define VRC_ASSERT_NEXT_ALWAYS(name, clk, pre, post)
`endif

`endif

[hdl/vrc_pkg.sv]
// ----------------------------------------------------------------------------
// vrc_pkg
// Widths, constants, stage payload type and saturation for the radius clamp.
// ----------------------------------------------------------------------------
package vrc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 4;
  localparam int WORK_FRAC    = 16;

  localparam int COORD_W  = 12;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int RAD_W    = 8;
  localparam int RAD_SQ_W = 2 * RAD_W;
  localparam int OUT_W    = 16;
  localparam int WORK_W   = 32;

  localparam int GAIN_W     = 30;
  localparam int PROD_W     = GAIN_W + RAD_W + 2;
  localparam int GAIN_SHIFT = 30 - WORK_FRAC;
  localparam logic [GAIN_W-1:0] GAIN_INV_Q30 = GAIN_W'(652032874);

  localparam int RND_SHIFT = WORK_FRAC - FRAC_BITS;
  localparam logic signed [WORK_W-1:0] RND_HALF = WORK_W'(1 << (RND_SHIFT - 1));

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(20);

  localparam logic signed [WORK_W-1:0] SAT_HI = WORK_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [WORK_W-1:0] SAT_LO = WORK_W'(-(1 << (OUT_W - 1)));

  typedef struct packed {
    logic                       vld;
    logic                       in_range;
    logic                       flip;
    logic signed [WORK_W-1:0]   x;
    logic signed [WORK_W-1:0]   y;
    logic signed [WORK_W-1:0]   ux;
    logic signed [WORK_W-1:0]   uy;
    logic signed [COORD_W-1:0]  tx;
    logic signed [COORD_W-1:0]  ty;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
  } cord_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WORK_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WORK_W-1:0] sext_coord(input logic signed [COORD_W-1:0] v);
    return {{(WORK_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

[hdl/vrc_in_if.sv]
// ----------------------------------------------------------------------------
// vrc_in_if
// Query channel: target and center point, valid/ready.
// ----------------------------------------------------------------------------
interface vrc_in_if import vrc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;

  modport source (output valid, target_x, target_y, center_x, center_y, input ready);
  modport sink   (input valid, target_x, target_y, center_x, center_y, output ready);
endinterface

[hdl/vrc_out_if.sv]
// ----------------------------------------------------------------------------
// vrc_out_if
// Result channel: clamped point and flag, valid/ready.
// ----------------------------------------------------------------------------
interface vrc_out_if import vrc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic                    was_clamped;

  modport source (output valid, out_x, out_y, was_clamped, input ready);
  modport sink   (input valid, out_x, out_y, was_clamped, output ready);
endinterface

[hdl/vector_radius_clamp.sv]
// ----------------------------------------------------------------------------
// vector_radius_clamp
// Clamps a target point to a circle of programmable radius about a center.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  query    in   valid/ready   target_x, target_y, center_x, center_y
//  result   out  valid/ready   out_x, out_y, was_clamped
//  radius   in   write enable  clamp_radius_data (8 bit)
//
//  One transfer per clock while the pipeline is not stalled; 3 front stages,
//  one stage per CORDIC step, 2 output stages.
//  Synchronous reset clears all valid bits and sets the radius to 20.
//  Whole pipeline advances when the result register is empty or taken;
//  a stall freezes every stage, query.ready follows it and is low in reset.
// ----------------------------------------------------------------------------
`include "vector_radius_clamp_defines.svh"

module vector_radius_clamp import vrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  vrc_in_if.sink           query,
  vrc_out_if.source        result,
  input  logic             clamp_radius_we,
  input  logic [RAD_W-1:0] clamp_radius_data
);

  logic [RAD_W-1:0] clamp_radius;
  logic             en;
  cord_t            f_out;
  cord_t            c_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_radius <= RADIUS_RESET;
    end else if (clamp_radius_we) begin
      clamp_radius <= clamp_radius_data;
    end
  end

  assign en = ~result.valid | result.ready;

  vrc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .query  (query),
    .radius (clamp_radius),
    .f_out  (f_out)
  );

  vrc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .c_in  (f_out),
    .c_out (c_out)
  );

  vrc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .c_in   (c_out),
    .result (result)
  );

  `VRC_ASSERT_NEXT_ALWAYS(a_rst_clears_out, clk, rst, !result.valid)
  `VRC_ASSERT_NEXT(a_stall_front, clk, rst, !rst && !en, $stable(f_out))
  `VRC_ASSERT_NEXT(a_stall_cordic, clk, rst, !rst && !en, $stable(c_out))

endmodule

[hdl/vrc_front.sv]
// ----------------------------------------------------------------------------
// vrc_front
// Offset, squared length test and CORDIC start vectors over three stages.
// ----------------------------------------------------------------------------
module vrc_front import vrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  vrc_in_if.sink           query,
  input  logic [RAD_W-1:0] radius,
  output cord_t            f_out
);

  // stage 1
  logic                      vld1;
  logic signed [DIFF_W-1:0]  dx1;
  logic signed [DIFF_W-1:0]  dy1;
  logic [RAD_W-1:0]          r1;
  logic signed [COORD_W-1:0] tx1, ty1, cx1, cy1;

  // stage 2
  logic                      vld2;
  logic [SQ_W-1:0]           dx2;
  logic [SQ_W-1:0]           dy2;
  logic [RAD_SQ_W-1:0]       r2;
  logic                      flip2;
  logic signed [WORK_W-1:0]  x2, y2, ux2;
  logic signed [COORD_W-1:0] tx2, ty2, cx2, cy2;

  logic signed [DIFF_W-1:0]  dxa;
  logic signed [DIFF_W-1:0]  dya;
  logic signed [SQ_W-1:0]    dxsq;
  logic signed [SQ_W-1:0]    dysq;
  logic [PROD_W-1:0]         gprod;
  logic [SQ_W:0]             dist2;
  cord_t                     f_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= query.valid;
    end
    if (en) begin
      dx1 <= DIFF_W'(query.target_x) - DIFF_W'(query.center_x);
      dy1 <= DIFF_W'(query.target_y) - DIFF_W'(query.center_y);
      r1  <= radius;
      tx1 <= query.target_x;
      ty1 <= query.target_y;
      cx1 <= query.center_x;
      cy1 <= query.center_y;
    end
  end

  always_comb begin
    dxa   = dx1[DIFF_W-1] ? -dx1 : dx1;
    dya   = dx1[DIFF_W-1] ? -dy1 : dy1;
    dxsq  = SQ_W'(dx1) * SQ_W'(dx1);
    dysq  = SQ_W'(dy1) * SQ_W'(dy1);
    gprod = PROD_W'(r1) * PROD_W'(GAIN_INV_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
    if (en) begin
      dx2   <= dxsq;
      dy2   <= dysq;
      r2    <= RAD_SQ_W'(r1) * RAD_SQ_W'(r1);
      flip2 <= dx1[DIFF_W-1];
      x2    <= {{(WORK_W-DIFF_W){dxa[DIFF_W-1]}}, dxa} <<< WORK_FRAC;
      y2    <= {{(WORK_W-DIFF_W){dya[DIFF_W-1]}}, dya} <<< WORK_FRAC;
      ux2   <= WORK_W'(gprod >> GAIN_SHIFT);
      tx2   <= tx1;
      ty2   <= ty1;
      cx2   <= cx1;
      cy2   <= cy1;
    end
  end

  always_comb begin
    dist2           = {1'b0, dx2} + {1'b0, dy2};
    f_next.vld      = vld2;
    f_next.in_range = dist2 <= (SQ_W+1)'(r2);
    f_next.flip     = flip2;
    f_next.x        = x2;
    f_next.y        = y2;
    f_next.ux       = ux2;
    f_next.uy       = '0;
    f_next.tx       = tx2;
    f_next.ty       = ty2;
    f_next.cx       = cx2;
    f_next.cy       = cy2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_out.vld <= 1'b0;
    end else if (en) begin
      f_out <= f_next;
    end
  end

  assign query.ready = en & ~rst;

endmodule

[hdl/vrc_cordic.sv]
// ----------------------------------------------------------------------------
// vrc_cordic
// One register stage per CORDIC step: vectoring on the offset and rotation
// of the radius vector run side by side, sharing the direction bit.
// ----------------------------------------------------------------------------
module vrc_cordic import vrc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cord_t c_in,
  output cord_t c_out
);

  cord_t pipe [0:CORDIC_STEPS];

  assign pipe[0] = c_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cord_t                    nxt;
    logic                     dir;
    logic signed [WORK_W-1:0] xs, ys, uxs, uys;

    always_comb begin
      dir = ~pipe[i].y[WORK_W-1];
      xs  = signed'(pipe[i].x)  >>> i;
      ys  = signed'(pipe[i].y)  >>> i;
      uxs = signed'(pipe[i].ux) >>> i;
      uys = signed'(pipe[i].uy) >>> i;
      nxt = pipe[i];
      if (dir) begin
        nxt.x  = pipe[i].x + ys;
        nxt.y  = pipe[i].y - xs;
        nxt.ux = pipe[i].ux - uys;
        nxt.uy = pipe[i].uy + uxs;
      end else begin
        nxt.x  = pipe[i].x - ys;
        nxt.y  = pipe[i].y + xs;
        nxt.ux = pipe[i].ux + uys;
        nxt.uy = pipe[i].uy - uxs;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[i+1].vld <= 1'b0;
      end else if (en) begin
        pipe[i+1] <= nxt;
      end
    end
  end

  assign c_out = pipe[CORDIC_STEPS];

endmodule

[hdl/vrc_back.sv]
// ----------------------------------------------------------------------------
// vrc_back
// Sign restore and rounding, then center add (or the target itself when in range),
// saturation and output register.
module vrc_back import vrc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cord_t c_in,
  vrc_out_if.source result
);

  logic                      vld_b;
  logic                      inside_b;
  logic signed [WORK_W-1:0]  rx, ry;
  logic signed [COORD_W-1:0] tx_b, ty_b, cx_b, cy_b;

  logic signed [WORK_W-1:0]  vx, vy;
  logic signed [WORK_W-1:0]  sum_x, sum_y, tsc_x, tsc_y;

  always_comb begin
    vx = c_in.flip ? RND_HALF - c_in.ux : c_in.ux + RND_HALF;
    vy = c_in.flip ? RND_HALF - c_in.uy : c_in.uy + RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (en) begin
      vld_b <= c_in.vld;
    end
    if (en) begin
      inside_b <= c_in.in_range;
      rx       <= vx >>> RND_SHIFT;
      ry       <= vy >>> RND_SHIFT;
      tx_b     <= c_in.tx;
      ty_b     <= c_in.ty;
      cx_b     <= c_in.cx;
      cy_b     <= c_in.cy;
    end
  end

  always_comb begin
    tsc_x = sext_coord(tx_b) <<< FRAC_BITS;
    tsc_y = sext_coord(ty_b) <<< FRAC_BITS;
    sum_x = (sext_coord(cx_b) <<< FRAC_BITS) + rx;
    sum_y = (sext_coord(cy_b) <<< FRAC_BITS) + ry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vld_b;
    end
    if (en) begin
      result.out_x       <= sat_out(inside_b ? tsc_x : sum_x);
      result.out_y       <= sat_out(inside_b ? tsc_y : sum_y);
      result.was_clamped <= ~inside_b;
    end
  end

endmodule
